@@ hdl/pnr_pkg.sv @@
// ----------------------------------------------------------------------------
// pnr_pkg: shared types and constants for the stereo panner
// Widths, pan-law constants, register indexes and the gain bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnr_pkg;

  // field widths
  localparam int SampleW = 16;
  localparam int PanW    = 15;
  localparam int GainW   = 16;
  localparam int MagW    = 14;
  localparam int CfgIdxW = 1;

  // pan law: far gain = floor((limit - |pan|) * 32768 / limit)
  localparam logic [MagW-1:0]  PanLimit = 14'd10000;
  localparam logic [GainW-1:0] UnityQ15 = 16'h8000;

  // 32768 / 10000 = 2048 / 625, done as a multiply by ceil(2^34 / 625) and >> 23
  localparam int RecipW     = 25;
  localparam int RecipShift = 23;
  localparam logic [RecipW-1:0] RecipQ = 25'd27487791;

  // Q15 product scaling and output clamp
  localparam int ProdW  = SampleW + GainW + 1;
  localparam int FracW  = 15;
  localparam int ShiftW = ProdW - FracW;
  localparam logic signed [SampleW-1:0] SatMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SatMin = -16'sh8000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PAN  = 1'b0,
    REG_MODE = 1'b1
  } pnr_reg_e;

  // per-side gains, unsigned Q15
  typedef struct packed {
    logic [GainW-1:0] left;
    logic [GainW-1:0] right;
  } pnr_gains_t;

endpackage

`default_nettype wire

@@ hdl/pnr_gain.sv @@
// ----------------------------------------------------------------------------
// pnr_gain: pan position to Q15 gain pair
// Clamps the pan, computes the far-side linear gain and registers both gains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnr_gain (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic signed [pnr_pkg::PanW-1:0]    pan_i,
  output pnr_pkg::pnr_gains_t                     gains_o
);

  localparam int MulW = pnr_pkg::MagW + pnr_pkg::RecipW;

  logic [pnr_pkg::PanW-1:0]  pan_mag;
  logic [pnr_pkg::MagW-1:0]  mag_clamped;
  logic [pnr_pkg::MagW-1:0]  far_m;
  logic [MulW-1:0]           far_prod;
  logic [pnr_pkg::GainW-1:0] far_gain;
  logic                      pan_right;
  pnr_pkg::pnr_gains_t       gains_d, gains_q;

  // magnitude, clamped to the pan limit
  assign pan_mag     = pan_i[pnr_pkg::PanW-1] ? pnr_pkg::PanW'(~pan_i + 1'b1)
                                              : pnr_pkg::PanW'(pan_i);
  assign mag_clamped = (pan_mag > pnr_pkg::PanW'(pnr_pkg::PanLimit)) ? pnr_pkg::PanLimit
                                                                     : pan_mag[pnr_pkg::MagW-1:0];
  assign far_m       = pnr_pkg::PanLimit - mag_clamped;

  // far gain by reciprocal multiply, exact floor over the whole range
  assign far_prod = MulW'(far_m) * MulW'(pnr_pkg::RecipQ);
  assign far_gain = far_prod[pnr_pkg::RecipShift +: pnr_pkg::GainW];

  // near side stays at unity
  assign pan_right     = !pan_i[pnr_pkg::PanW-1] && (pan_i != '0);
  assign gains_d.left  = pan_right ? far_gain : pnr_pkg::UnityQ15;
  assign gains_d.right = pan_i[pnr_pkg::PanW-1] ? far_gain : pnr_pkg::UnityQ15;

  // gain register, follows the pan register in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '{left: pnr_pkg::UnityQ15, right: pnr_pkg::UnityQ15};
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

`default_nettype wire

@@ hdl/pnr_scale.sv @@
// ----------------------------------------------------------------------------
// pnr_scale: one channel of Q15 gain scaling
// Multiplies a sample by an unsigned Q15 gain, floors by 2^15, saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnr_scale (
  input  wire logic signed [pnr_pkg::SampleW-1:0] sample_i,
  input  wire logic        [pnr_pkg::GainW-1:0]   gain_i,
  output logic signed      [pnr_pkg::SampleW-1:0] result_o
);

  logic signed [pnr_pkg::GainW:0]      gain_s;
  logic signed [pnr_pkg::ProdW-1:0]    prod;
  logic signed [pnr_pkg::ShiftW-1:0]   shifted;

  // signed multiply, arithmetic shift rounds toward minus infinity
  assign gain_s  = $signed({1'b0, gain_i});
  assign prod    = pnr_pkg::ProdW'(sample_i) * pnr_pkg::ProdW'(gain_s);
  assign shifted = prod[pnr_pkg::ProdW-1:pnr_pkg::FracW];

  // clamp to 16 bits
  always_comb begin
    if (shifted > pnr_pkg::ShiftW'(pnr_pkg::SatMax)) begin
      result_o = pnr_pkg::SatMax;
    end else if (shifted < pnr_pkg::ShiftW'(pnr_pkg::SatMin)) begin
      result_o = pnr_pkg::SatMin;
    end else begin
      result_o = shifted[pnr_pkg::SampleW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/pcm_stereo_panner_q15_core.sv @@
// ----------------------------------------------------------------------------
// pcm_stereo_panner_q15_core: linear pan law stereo panner, 16-bit PCM
// Input register, two gain multipliers with saturation, output register.
// ----------------------------------------------------------------------------
// One frame beat in, one panned frame beat out. The block takes a new frame
// every cycle while the output is not stalled; an accepted frame passes the
// input register, then the result register holding the two Q15 products.
// The gain pair is derived from the pan register and registered, so it
// follows a configuration write through the pan and then the gain register.
// In mono mode the left sample feeds both sides; in stereo mode each side
// is scaled separately. The far side gain is floor((10000 - |pan|) * 32768
// / 10000) with pan clamped to +-10000; the near side is unity. Output
// stall holds the result register and backs up into the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcm_stereo_panner_q15_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [pnr_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [pnr_pkg::PanW-1:0]            cfg_wdata_i,
  // input frames
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [pnr_pkg::SampleW-1:0]  left_sample_i,
  input  wire logic signed [pnr_pkg::SampleW-1:0]  right_sample_i,
  input  wire logic                                frame_last_i,
  // output frames
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [pnr_pkg::SampleW-1:0]       left_out_o,
  output logic signed [pnr_pkg::SampleW-1:0]       right_out_o,
  output logic                                     out_last_o
);

  logic signed [pnr_pkg::PanW-1:0]    pan_q;
  logic                               stereo_q;
  pnr_pkg::pnr_gains_t                gains;

  logic                               s1_valid_q;
  logic signed [pnr_pkg::SampleW-1:0] s1_left_q, s1_right_q;
  logic                               s1_last_q;
  logic                               s1_adv, s2_load, in_take;

  logic signed [pnr_pkg::SampleW-1:0] left_res, right_res;
  logic                               s2_valid_q;
  logic signed [pnr_pkg::SampleW-1:0] s2_left_q, s2_right_q;
  logic                               s2_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q    <= '0;
      stereo_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pnr_pkg::pnr_reg_e'(cfg_idx_i))
        pnr_pkg::REG_PAN:  pan_q    <= cfg_wdata_i;
        pnr_pkg::REG_MODE: stereo_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // gain pair
  pnr_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pan_i   (pan_q),
    .gains_o (gains)
  );

  // pipeline flow control
  assign s2_load    = !s2_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_load;
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register, mono mode duplicates the left sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_left_q  <= left_sample_i;
      s1_right_q <= stereo_q ? right_sample_i : left_sample_i;
      s1_last_q  <= frame_last_i;
    end
  end

  // per-side scaling
  pnr_scale u_scale_left (
    .sample_i (s1_left_q),
    .gain_i   (gains.left),
    .result_o (left_res)
  );

  pnr_scale u_scale_right (
    .sample_i (s1_right_q),
    .gain_i   (gains.right),
    .result_o (right_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_left_q  <= left_res;
      s2_right_q <= right_res;
      s2_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign left_out_o  = s2_left_q;
  assign right_out_o = s2_right_q;
  assign out_last_o  = s2_last_q;

endmodule

`default_nettype wire
